### design/hrk_pkg.sv
`timescale 1ns / 1ps

package hrk_pkg;

  // Default sizes of the constant table and the permutation.
  localparam int unsigned CONSTANT_ENTRIES_DEF = 40;
  localparam int unsigned ROUNDS_DEF = 5;

  // Item codes.
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_HASH = 1'b1;
  localparam logic [1:0] VAR_512_TABLE = 2'd0;
  localparam logic [1:0] VAR_512_ZERO = 2'd1;
  localparam logic [1:0] VAR_256 = 2'd2;

  typedef struct packed {
    logic        action;
    logic [1:0]  variant;
    logic [6:0]  table_index;
    logic [63:0] const_word;
    logic [63:0] msg_word0;
    logic [63:0] msg_word1;
    logic [63:0] msg_word2;
    logic [63:0] msg_word3;
    logic [63:0] msg_word4;
    logic [63:0] msg_word5;
    logic [63:0] msg_word6;
    logic [63:0] msg_word7;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_word0;
    logic [63:0] digest_word1;
    logic [63:0] digest_word2;
    logic [63:0] digest_word3;
  } out_item_t;

  // AES S-box.
  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

endpackage

### design/hrk_key_store.sv
`timescale 1ns / 1ps

module hrk_key_store #(
  parameter int unsigned CONSTANT_ENTRIES = hrk_pkg::CONSTANT_ENTRIES_DEF,
  localparam int unsigned EW = $clog2(CONSTANT_ENTRIES)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [6:0]    wr_slot,
  input  logic [63:0]   wr_data,
  input  logic [EW-1:0] rd_entry,
  output logic [127:0]  rd_key
);
  import hrk_pkg::*;

  // One memory per key half, so a whole 128-bit key is read each cycle.
  logic [63:0] mem_lo [CONSTANT_ENTRIES];
  logic [63:0] mem_hi [CONSTANT_ENTRIES];
  logic        slot_ok;

  assign slot_ok = wr_slot[6:1] < 6'(CONSTANT_ENTRIES);

  // Writes to slots beyond the table are dropped.
  always_ff @(posedge clk) begin
    if (wr_en && slot_ok && !wr_slot[0]) begin
      mem_lo[wr_slot[EW:1]] <= wr_data;
    end
    if (wr_en && slot_ok && wr_slot[0]) begin
      mem_hi[wr_slot[EW:1]] <= wr_data;
    end
    rd_key <= {mem_hi[rd_entry], mem_lo[rd_entry]};
  end

endmodule

### design/hrk_aes_round.sv
`timescale 1ns / 1ps

module hrk_aes_round (
  input  logic [127:0] lane_in,
  input  logic [127:0] key,
  output logic [127:0] lane_out
);
  import hrk_pkg::*;

  function automatic logic [7:0] xt(input logic [7:0] x);
    xt = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  logic [7:0] t [16];

  // ShiftRows and SubBytes.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[4*c+r] = SBOX[lane_in[8*(4*((c+r)%4)+r) +: 8]];
      end
    end
  end

  // MixColumns and round key.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      lane_out[8*(4*c)   +: 8] = xt(t[4*c]) ^ xt(t[4*c+1]) ^ t[4*c+1] ^ t[4*c+2]
                                 ^ t[4*c+3] ^ key[8*(4*c) +: 8];
      lane_out[8*(4*c+1) +: 8] = t[4*c] ^ xt(t[4*c+1]) ^ xt(t[4*c+2]) ^ t[4*c+2]
                                 ^ t[4*c+3] ^ key[8*(4*c+1) +: 8];
      lane_out[8*(4*c+2) +: 8] = t[4*c] ^ t[4*c+1] ^ xt(t[4*c+2]) ^ xt(t[4*c+3])
                                 ^ t[4*c+3] ^ key[8*(4*c+2) +: 8];
      lane_out[8*(4*c+3) +: 8] = xt(t[4*c]) ^ t[4*c] ^ t[4*c+1] ^ t[4*c+2]
                                 ^ xt(t[4*c+3]) ^ key[8*(4*c+3) +: 8];
    end
  end

endmodule

### design/haraka_short_input_hash.sv
`timescale 1ns / 1ps

// Haraka v2 short-input hash engine. A load item (action 0) writes one
// 64-bit half of a round constant into the constant table. A hash item
// runs Haraka-512 (table or zero constants) or Haraka-256 on the message
// and returns one item with four digest words. One AES round unit is
// shared by all lanes and does one lane per cycle, and the constant memory
// has a registered read. Constants must be loaded before a hash item
// reads them.
module haraka_short_input_hash #(
  parameter int unsigned CONSTANT_ENTRIES = hrk_pkg::CONSTANT_ENTRIES_DEF,
  parameter int unsigned ROUNDS = hrk_pkg::ROUNDS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  hrk_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output hrk_pkg::out_item_t out_item
);
  import hrk_pkg::*;

  localparam int unsigned EW = $clog2(CONSTANT_ENTRIES);
  localparam int unsigned RW = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

  typedef enum logic [1:0] {S_IDLE, S_PRIME, S_RUN, S_DONE} state_t;

  function automatic logic [127:0] ilv(input logic [127:0] a, input logic [127:0] b,
                                       input logic hi);
    if (hi) begin
      ilv = {b[127:96], a[127:96], b[95:64], a[95:64]};
    end else begin
      ilv = {b[63:32], a[63:32], b[31:0], a[31:0]};
    end
  endfunction

  state_t        state_r, state_nxt;
  logic [511:0]  st_r, st_nxt;
  logic [511:0]  msg_r, msg_nxt;
  logic          zero_key_r, zero_key_nxt;
  logic          is256_r, is256_nxt;
  logic [EW-1:0] ptr_r, ptr_nxt;
  logic [1:0]    lane_r, lane_nxt;
  logic          half_r, half_nxt;
  logic [RW-1:0] round_r, round_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_r, out_nxt;

  logic          accept;
  logic [127:0]  key_rd, key, lane_in, lane_out;
  logic [511:0]  upd, mixed, ff;
  logic [127:0]  tmp, s0a, s1a, s2a, s3a, s0b, s1b, s2b;
  logic [EW-1:0] ptr_inc;
  logic          last_lane;

  assign in_stall = state_r != S_IDLE;
  assign accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_item = out_r;

  hrk_key_store #(.CONSTANT_ENTRIES(CONSTANT_ENTRIES)) u_keys (
    .clk      (clk),
    .wr_en    (accept && in_item.action == ACT_LOAD),
    .wr_slot  (in_item.table_index),
    .wr_data  (in_item.const_word),
    .rd_entry (ptr_r),
    .rd_key   (key_rd)
  );

  // Shared round unit on the selected lane.
  assign key = zero_key_r ? '0 : key_rd;
  assign lane_in = st_r[128*lane_r +: 128];

  hrk_aes_round u_round (
    .lane_in  (lane_in),
    .key      (key),
    .lane_out (lane_out)
  );

  always_comb begin
    upd = st_r;
    upd[128*lane_r +: 128] = lane_out;
  end

  // Word interleave after the second AES pass of a round.
  always_comb begin
    tmp = ilv(upd[127:0], upd[255:128], 1'b0);
    s0a = ilv(upd[127:0], upd[255:128], 1'b1);
    s1a = ilv(upd[383:256], upd[511:384], 1'b0);
    s2a = ilv(upd[383:256], upd[511:384], 1'b1);
    s3a = ilv(s0a, s2a, 1'b0);
    s0b = ilv(s0a, s2a, 1'b1);
    s2b = ilv(s1a, tmp, 1'b1);
    s1b = ilv(s1a, tmp, 1'b0);
    if (is256_r) begin
      mixed = {upd[511:256], ilv(upd[127:0], upd[255:128], 1'b1), tmp};
    end else begin
      mixed = {s3a, s2b, s1b, s0b};
    end
  end

  // Feed-forward and digest selection.
  always_comb begin
    ff = st_r ^ msg_r;
    if (is256_r) begin
      out_nxt = {ff[63:0], ff[127:64], ff[191:128], ff[255:192]};
    end else begin
      out_nxt = {ff[127:64], ff[255:192], ff[319:256], ff[447:384]};
    end
  end

  assign ptr_inc = (ptr_r == EW'(CONSTANT_ENTRIES - 1)) ? '0 : ptr_r + 1'b1;
  assign last_lane = is256_r ? (lane_r == 2'd1) : (lane_r == 2'd3);

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    st_nxt = st_r;
    msg_nxt = msg_r;
    zero_key_nxt = zero_key_r;
    is256_nxt = is256_r;
    ptr_nxt = ptr_r;
    lane_nxt = lane_r;
    half_nxt = half_r;
    round_nxt = round_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_item.action == ACT_HASH) begin
          msg_nxt = {in_item.msg_word7, in_item.msg_word6, in_item.msg_word5,
                     in_item.msg_word4, in_item.msg_word3, in_item.msg_word2,
                     in_item.msg_word1, in_item.msg_word0};
          st_nxt = msg_nxt;
          zero_key_nxt = in_item.variant == VAR_512_ZERO;
          is256_nxt = in_item.variant[1];
          ptr_nxt = '0;
          lane_nxt = '0;
          half_nxt = 1'b0;
          round_nxt = '0;
          state_nxt = S_PRIME;
        end
      end
      S_PRIME: begin
        ptr_nxt = ptr_inc;
        state_nxt = S_RUN;
      end
      S_RUN: begin
        ptr_nxt = ptr_inc;
        st_nxt = upd;
        lane_nxt = lane_r + 1'b1;
        if (last_lane) begin
          lane_nxt = '0;
          half_nxt = !half_r;
          if (half_r) begin
            st_nxt = mixed;
            round_nxt = round_r + 1'b1;
            if (round_r == RW'(ROUNDS - 1)) begin
              state_nxt = S_DONE;
            end
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    st_r <= st_nxt;
    msg_r <= msg_nxt;
    zero_key_r <= zero_key_nxt;
    is256_r <= is256_nxt;
    ptr_r <= ptr_nxt;
    lane_r <= lane_nxt;
    half_r <= half_nxt;
    round_r <= round_nxt;
    if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
      out_r <= out_nxt;
    end
  end

endmodule
